// ===== hdl/iwsfd_pkg.sv =====
// Package with the types, constants and helper functions of the info word stream flag decoder.
`timescale 1ns / 1ps
`default_nettype none

package iwsfd_pkg;

   localparam int unsigned NUM_CHANNELS = 26;
   localparam int unsigned NUM_TDC      = 10;
   localparam int unsigned NUM_MESSAGES = 19;

   localparam int unsigned CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int unsigned TDC_IDX_W = (NUM_TDC > 1) ? $clog2(NUM_TDC) : 1;

   localparam logic [4:0] MAP_ANNOUNCE = 5'h1f;

   // Request opcodes.
   localparam logic [1:0] OP_INFO   = 2'd0;
   localparam logic [1:0] OP_ENERGY = 2'd1;
   localparam logic [1:0] OP_TDC    = 2'd2;

   // Decoder phases; the unused code acts as the plain phase.
   localparam logic [1:0] PHASE_PLAIN    = 2'd0;
   localparam logic [1:0] PHASE_MAP_LOW  = 2'd1;
   localparam logic [1:0] PHASE_MAP_HIGH = 2'd2;

   // Error codes of a result.
   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_HALTED    = 2'd1;
   localparam logic [1:0] ERR_NO_CHAN   = 2'd2;
   localparam logic [1:0] ERR_UNMANAGED = 2'd3;

   // Message codes that steer the implicit pedestal flags.
   localparam int unsigned C_TDC_PED_QC      = 1;
   localparam int unsigned C_TDC_PED_MISSING = 2;
   localparam int unsigned C_ADC_PED_OR      = 3;
   localparam int unsigned C_ADC_PED_QC      = 4;
   localparam int unsigned C_ADC_PED_MISSING = 5;

   typedef logic [NUM_MESSAGES-1:0] msg_row_type;
   typedef logic [NUM_CHANNELS-1:0] chan_mask_type;
   typedef logic [NUM_TDC-1:0]      tdc_mask_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        event_start;
      logic [15:0] info_word;
      logic [4:0]  channel;
      logic        tdc_begin;
      logic        tdc_end;
   } req_type;

   typedef struct packed {
      logic [4:0] entry_channel;
      logic [9:0] entry_code;
      logic       flag_value;
      logic [1:0] error_code;
      logic       last;
   } rsp_type;

   // Reads the flag of one fixed message code; codes beyond the row read as zero.
   function automatic logic msg_bit(input msg_row_type row, input int unsigned code);
      logic [63:0] wide;
      wide = 64'(row);
      return (code < NUM_MESSAGES) && wide[code[5:0]];
   endfunction

   // Sets the flag of a message code taken from a word.
   function automatic msg_row_type set_code(input msg_row_type row, input logic [9:0] code);
      msg_row_type res;
      res = row;
      for (int b = 0; b < NUM_MESSAGES; b++) begin
         if (code == 10'(b)) begin
            res[b] = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/info_word_stream_flag_decoder.sv =====
// Top level of the info word stream flag decoder.
//
// A request enters on req_valid/req_ready and lands in a one-entry input
// buffer; req_ready is high whenever that buffer is empty, also while a
// result waits on the rsp channel. The sequencer decodes the buffered
// request once the output register is free and registers its result there;
// a new request is accepted only after the buffer has emptied.
// The second word of a channel map starts a scan that visits one channel per
// cycle, up to the highest channel set in the map, and sends one result for
// each mapped channel; the flag store is updated by the same per-channel step.
// The last result of a request carries last. A request that gives no result
// (map announcement, first map word, halted event, no-operation) simply
// leaves the buffer. When the receiver stalls, the output register holds its
// result and the scan waits; one more request may still be buffered.
// Synchronous reset clears all flags, the decoder phase, the halt and both
// valid bits; event_start clears the flags, the phase and the halt just before its request.
`timescale 1ns / 1ps
`default_nettype none

module info_word_stream_flag_decoder
   import iwsfd_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_ready,
   output rsp_type rsp_data
);

   state_type     state_ff, state_in;
   logic          in_valid_ff, in_valid_in;
   req_type       in_data_ff, in_data_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [1:0]    phase_ff, phase_in;
   logic [9:0]    pcode_ff, pcode_in;
   logic [14:0]   map_low_ff, map_low_in;
   logic          halted_ff, halted_in;
   msg_row_type   flags_ff [NUM_CHANNELS];
   msg_row_type   flags_in [NUM_CHANNELS];
   chan_mask_type adc_ff, adc_in;
   tdc_mask_type  tdc_ff, tdc_in;

   chan_mask_type scan_map_ff, scan_map_in;
   logic [CH_IDX_W-1:0] scan_ch_ff, scan_ch_in;

   logic          out_free;
   logic          process;
   logic          scan_done;
   logic          mark;
   logic [4:0]    word_ch;
   logic [9:0]    word_code;
   logic [29:0]   full_map;
   chan_mask_type new_map;
   logic [1:0]    cur_phase;
   logic          cur_halted;
   logic [CH_IDX_W-1:0]  ch_idx;
   logic [TDC_IDX_W-1:0] tdc_idx;
   msg_row_type   row;

   assign req_ready = !in_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign process   = (state_ff == ST_IDLE) && in_valid_ff && out_free;
   assign scan_done = (scan_map_ff >> 1) == '0;

   assign mark      = in_data_ff.info_word[15];
   assign word_ch   = in_data_ff.info_word[14:10];
   assign word_code = in_data_ff.info_word[9:0];
   assign full_map  = {in_data_ff.info_word[14:0], map_low_ff};
   assign new_map   = full_map[NUM_CHANNELS-1:0];

   // Phase and halt as the buffered request sees them, after any event_start clearing.
   assign cur_phase  = in_data_ff.event_start ? PHASE_PLAIN : phase_ff;
   assign cur_halted = halted_ff && !in_data_ff.event_start;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (process && !cur_halted && in_data_ff.opcode == OP_INFO &&
                cur_phase == PHASE_MAP_HIGH && mark && new_map != '0) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((out_free || !scan_map_ff[0]) && scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and result generation.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      phase_in    = phase_ff;
      pcode_in    = pcode_ff;
      map_low_in  = map_low_ff;
      halted_in   = halted_ff;
      flags_in    = flags_ff;
      adc_in      = adc_ff;
      tdc_in      = tdc_ff;
      scan_map_in = scan_map_ff;
      scan_ch_in  = scan_ch_ff;

      ch_idx  = in_data_ff.channel[CH_IDX_W-1:0];
      tdc_idx = in_data_ff.channel[TDC_IDX_W-1:0];
      row     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (process) begin
               in_valid_in = 1'b0;
               if (in_data_ff.event_start) begin
                  phase_in   = PHASE_PLAIN;
                  pcode_in   = '0;
                  map_low_in = '0;
                  halted_in  = 1'b0;
                  adc_in     = '0;
                  tdc_in     = '0;
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                     flags_in[i] = '0;
                  end
               end
               if (in_data_ff.channel < 5'(NUM_CHANNELS)) begin
                  row = flags_in[ch_idx];
               end

               rsp_data_in.entry_channel = in_data_ff.channel;
               rsp_data_in.entry_code    = '0;
               rsp_data_in.flag_value    = 1'b0;
               rsp_data_in.error_code    = ERR_OK;
               rsp_data_in.last          = 1'b1;

               unique case (in_data_ff.opcode)
                  OP_INFO: begin
                     if (!halted_in) begin
                        if ((phase_in == PHASE_MAP_LOW || phase_in == PHASE_MAP_HIGH) !=
                            mark) begin
                           // A map word where a plain word is due, or the reverse.
                           halted_in    = 1'b1;
                           phase_in     = PHASE_PLAIN;
                           rsp_valid_in = 1'b1;
                           rsp_data_in.entry_channel = '0;
                           rsp_data_in.error_code    = ERR_HALTED;
                        end else if (phase_in == PHASE_MAP_LOW) begin
                           map_low_in = in_data_ff.info_word[14:0];
                           phase_in   = PHASE_MAP_HIGH;
                        end else if (phase_in == PHASE_MAP_HIGH) begin
                           phase_in    = PHASE_PLAIN;
                           scan_map_in = new_map;
                           scan_ch_in  = '0;
                        end else if (word_ch == MAP_ANNOUNCE) begin
                           pcode_in = word_code;
                           phase_in = PHASE_MAP_LOW;
                        end else begin
                           phase_in     = PHASE_PLAIN;
                           rsp_valid_in = 1'b1;
                           rsp_data_in.entry_channel = word_ch;
                           rsp_data_in.entry_code    = word_code;
                           if (word_ch >= 5'(NUM_CHANNELS)) begin
                              rsp_data_in.error_code = ERR_NO_CHAN;
                           end else if (word_code >= 10'(NUM_MESSAGES)) begin
                              rsp_data_in.error_code = ERR_UNMANAGED;
                           end else begin
                              flags_in[word_ch[CH_IDX_W-1:0]] =
                                 set_code(flags_in[word_ch[CH_IDX_W-1:0]], word_code);
                           end
                        end
                     end
                  end
                  OP_ENERGY: begin
                     rsp_valid_in = 1'b1;
                     if (in_data_ff.channel >= 5'(NUM_CHANNELS)) begin
                        rsp_data_in.error_code = ERR_NO_CHAN;
                     end else begin
                        if (!msg_bit(row, C_ADC_PED_OR) && !msg_bit(row, C_ADC_PED_QC) &&
                            !msg_bit(row, C_ADC_PED_MISSING)) begin
                           adc_in[ch_idx] = 1'b1;
                        end
                        rsp_data_in.flag_value = adc_in[ch_idx];
                     end
                  end
                  OP_TDC: begin
                     rsp_valid_in = 1'b1;
                     if (in_data_ff.channel >= 5'(NUM_TDC)) begin
                        rsp_data_in.error_code = ERR_NO_CHAN;
                     end else begin
                        if (!msg_bit(row, C_TDC_PED_QC) && !msg_bit(row, C_TDC_PED_MISSING)) begin
                           tdc_in[tdc_idx] = 1'b1;
                        end
                        rsp_data_in.flag_value = tdc_in[tdc_idx];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // One channel of the map per step; unmapped channels pass without a result.
            if (out_free || !scan_map_ff[0]) begin
               if (scan_map_ff[0]) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in.entry_channel = 5'(scan_ch_ff);
                  rsp_data_in.entry_code    = pcode_ff;
                  rsp_data_in.flag_value    = 1'b0;
                  rsp_data_in.last          = scan_done;
                  if (pcode_ff >= 10'(NUM_MESSAGES)) begin
                     rsp_data_in.error_code = ERR_UNMANAGED;
                  end else begin
                     rsp_data_in.error_code = ERR_OK;
                     flags_in[scan_ch_ff] = set_code(flags_ff[scan_ch_ff], pcode_ff);
                  end
               end
               scan_map_in = scan_map_ff >> 1;
               scan_ch_in  = scan_ch_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PHASE_PLAIN;
         pcode_ff     <= '0;
         map_low_ff   <= '0;
         halted_ff    <= 1'b0;
         adc_ff       <= '0;
         tdc_ff       <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            flags_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         pcode_ff     <= pcode_in;
         map_low_ff   <= map_low_in;
         halted_ff    <= halted_in;
         adc_ff       <= adc_in;
         tdc_ff       <= tdc_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
      scan_map_ff <= scan_map_in;
      scan_ch_ff  <= scan_ch_in;
   end

endmodule

`default_nettype wire
